// ===== design/tss_pkg.sv =====
// Shared types, constants and helper functions of the texture sample and shade block.
// No dependencies; tss_addr, tss_store and texture_sample_shade import it (tss_ram does not).
package tss_pkg;

  localparam int IDX_W = 27;  // texel byte index: (y*w + x)*c with 12-bit dims, 3-bit channels
  localparam int LIN_W = 24;  // texel number y*w + x

  localparam logic [1:0] TEX_DIFFUSE  = 2'd0;
  localparam logic [1:0] TEX_EMISSIVE = 2'd1;
  localparam logic [1:0] TEX_OPACITY  = 2'd2;

  localparam logic [1:0] EM_NONE    = 2'd0;
  localparam logic [1:0] EM_TEXTURE = 2'd1;
  localparam logic [1:0] EM_CONST   = 2'd2;

  localparam logic [2:0] REG_DIFFUSE_SHAPE  = 3'd0;
  localparam logic [2:0] REG_EMISSIVE_SHAPE = 3'd1;
  localparam logic [2:0] REG_OPACITY_SHAPE  = 3'd2;
  localparam logic [2:0] REG_BASE_COLOR     = 3'd3;
  localparam logic [2:0] REG_EMISSIVE_ADD   = 3'd4;
  localparam logic [2:0] REG_MODE           = 3'd5;

  typedef struct packed {
    logic              req_type;
    logic [1:0]        tex_select;
    logic [15:0]       byte_addr;
    logic [7:0]        byte_value;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
  } req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } res_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } texel_t;

  // Texel location handed from the address unit to the store
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [2:0]       chans;
    logic             white;
  } tex_addr_t;

  function automatic logic shape_ok(input logic [26:0] shape, input int max_dim);
    logic [31:0] w;
    logic [31:0] h;
    w = {20'd0, shape[11:0]};
    h = {20'd0, shape[23:12]};
    return (w != 32'd0) && (h != 32'd0) && (shape[26:24] != 3'd0) &&
           (w <= 32'(max_dim)) && (h <= 32'(max_dim));
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

// ===== design/tss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tss_addr.sv =====
// Three-stage texel address unit for one texture: column/row, texel number, byte index.
// Depends on tss_pkg.
module tss_addr
  import tss_pkg::*;
#(
  parameter int TEX_BYTES = 65536,
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [2:0]           en,     // load enables of the three stages
  input  logic [26:0]          shape,
  input  logic [FRAC_BITS-1:0] fu,
  input  logic [FRAC_BITS:0]   fv,
  output tex_addr_t            taddr
);

  logic [11:0] w;
  logic [11:0] h;
  logic [2:0]  c;
  assign w = shape[11:0];
  assign h = shape[23:12];
  assign c = shape[26:24];

  // column and row
  logic [FRAC_BITS+11:0] px;
  logic [FRAC_BITS+12:0] py;
  logic [12:0]           yraw;
  logic [11:0]           hm1;
  logic [11:0]           x;
  logic [11:0]           y;

  assign px   = (FRAC_BITS+12)'(fu) * (FRAC_BITS+12)'(w);
  assign py   = (FRAC_BITS+13)'(fv) * (FRAC_BITS+13)'(h);
  assign yraw = py[FRAC_BITS+12:FRAC_BITS];
  assign hm1  = h - 12'd1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x <= px[FRAC_BITS+11:FRAC_BITS];  // fu below one keeps x below width
      y <= (yraw > {1'b0, hm1}) ? hm1 : yraw[11:0];
    end
  end

  // texel number
  logic [LIN_W-1:0] lin;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      lin <= LIN_W'(y) * LIN_W'(w) + LIN_W'(x);
    end
  end

  // byte index and bounds
  logic [IDX_W-1:0] idx;
  logic [31:0]      last;
  assign idx  = IDX_W'(lin) * IDX_W'(c);
  assign last = 32'(idx) + 32'(c) - 32'd1;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      taddr.idx   <= idx;
      taddr.chans <= c;
      taddr.white <= !shape_ok(shape, MAX_DIM) || (last >= 32'(TEX_BYTES));
    end
  end

endmodule

// ===== design/tss_store.sv =====
// Texel store of one texture: four byte banks so any four consecutive bytes are read together.
// Depends on tss_pkg and tss_ram.
module tss_store
  import tss_pkg::*;
#(
  parameter int TEX_BYTES = 65536
) (
  input  logic        clk,
  input  logic        en,        // read issue / load of the data stage
  input  tex_addr_t   taddr,
  input  logic        wr,        // write this cycle
  input  logic [15:0] waddr,
  input  logic [7:0]  wdata,
  output texel_t      texel
);

  localparam int BANK_DEPTH = TEX_BYTES / 4;
  localparam int BAW = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;

  logic [1:0]  off;
  logic [2:0]  chans;
  logic        white;
  logic [7:0]  bank_data [4];
  logic [31:0] wa;

  assign wa = 32'(waddr) >> 2;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [31:0] ra;
    // bytes below the start offset come from the next row of the bank
    assign ra = 32'(taddr.idx[IDX_W-1:2]) + 32'(2'(b) < taddr.idx[1:0]);
    tss_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_ram (
      .clk   (clk),
      .we    (wr && (waddr[1:0] == 2'(b))),
      .waddr (wa[BAW-1:0]),
      .wdata (wdata),
      .re    (en),
      .raddr (ra[BAW-1:0]),
      .rdata (bank_data[b])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off   <= taddr.idx[1:0];
      chans <= taddr.chans;
      white <= taddr.white;
    end
  end

  logic [7:0] b0, b1, b2, b3;
  always_comb begin
    b0 = bank_data[off];
    b1 = bank_data[off + 2'd1];
    b2 = bank_data[off + 2'd2];
    b3 = bank_data[off + 2'd3];
    if (white) begin
      texel = '{r: 8'hFF, g: 8'hFF, b: 8'hFF, a: 8'hFF};
    end else begin
      texel.r = b0;
      texel.g = (chans > 3'd1) ? b1 : b0;
      texel.b = (chans > 3'd2) ? b2 : b0;
      texel.a = (chans > 3'd3) ? b3 : 8'hFF;
    end
  end

endmodule

// ===== design/texture_sample_shade.sv =====
// One transaction per cycle sustained while the result output does not stall.
// Stages: input, texel column/row multiply, texel number, byte index, bank read, shade.
// A write transaction updates the selected store, if any, at the bank-read stage and yields no result.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
// Texel stores are not cleared; unwritten bytes read as undefined.
module texture_sample_shade
  import tss_pkg::*;
#(
  parameter int TEX_BYTES = 65536,
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- configuration registers ----------------
  logic [26:0] diffuse_shape, emissive_shape, opacity_shape;
  logic [31:0] base_color;
  logic [23:0] emissive_add;
  logic [3:0]  mode;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      diffuse_shape  <= '0;
      emissive_shape <= '0;
      opacity_shape  <= '0;
      base_color     <= 32'hFFFF_FFFF;
      emissive_add   <= '0;
      mode           <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_DIFFUSE_SHAPE:  diffuse_shape  <= pwdata[26:0];
        REG_EMISSIVE_SHAPE: emissive_shape <= pwdata[26:0];
        REG_OPACITY_SHAPE:  opacity_shape  <= pwdata[26:0];
        REG_BASE_COLOR:     base_color     <= pwdata;
        REG_EMISSIVE_ADD:   emissive_add   <= pwdata[23:0];
        REG_MODE:           mode           <= pwdata[3:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DIFFUSE_SHAPE:  prdata = 32'(diffuse_shape);
      REG_EMISSIVE_SHAPE: prdata = 32'(emissive_shape);
      REG_OPACITY_SHAPE:  prdata = 32'(opacity_shape);
      REG_BASE_COLOR:     prdata = base_color;
      REG_EMISSIVE_ADD:   prdata = 32'(emissive_add);
      REG_MODE:           prdata = 32'(mode);
      default:            prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // Each stage loads when it is empty or the next one loads; a stall
  // backs up only as far as the first empty stage.
  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5, en6;

  assign en6       = !res_valid || res_ready;
  assign en5       = !v5 || en6;
  assign en4       = !v4 || en5;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign req_ready = en1;

  // Kind and write payload ride along with the valid bits
  logic        smp1, smp2, smp3, smp4;
  logic [1:0]  sel1, sel2, sel3, sel4;
  logic [15:0] wad1, wad2, wad3, wad4;
  logic [7:0]  wdt1, wdt2, wdt3, wdt4;
  logic        aok1, aok2, aok3, aok4;
  logic signed [31:0] cu1, cv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4 && smp4;   // a write leaves the pipe here
      if (en6) res_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      smp1 <= req.req_type;
      sel1 <= req.tex_select;
      wad1 <= req.byte_addr;
      wdt1 <= req.byte_value;
      aok1 <= 32'(req.byte_addr) < 32'(TEX_BYTES);
      cu1  <= req.coord_u;
      cv1  <= req.coord_v;
    end
    if (en2) begin
      smp2 <= smp1; sel2 <= sel1; wad2 <= wad1; wdt2 <= wdt1; aok2 <= aok1;
    end
    if (en3) begin
      smp3 <= smp2; sel3 <= sel2; wad3 <= wad2; wdt3 <= wdt2; aok3 <= aok2;
    end
    if (en4) begin
      smp4 <= smp3; sel4 <= sel3; wad4 <= wad3; wdt4 <= wdt3; aok4 <= aok3;
    end
  end

  // ---------------- wrap and flip ----------------
  // Fraction is the low bits of the two's complement coordinate.
  logic [FRAC_BITS-1:0] fu;
  logic [FRAC_BITS:0]   fv;
  assign fu = cu1[FRAC_BITS-1:0];
  assign fv = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, cv1[FRAC_BITS-1:0]};

  // ---------------- address units and stores ----------------
  tex_addr_t ta_d, ta_e, ta_o;
  texel_t    tx_d, tx_e, tx_o;
  logic      wr_go;

  assign wr_go = en5 && v4 && !smp4 && aok4;

  tss_addr #(.TEX_BYTES(TEX_BYTES), .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_addr_d (
    .clk(clk), .en({en4, en3, en2}), .shape(diffuse_shape), .fu(fu), .fv(fv), .taddr(ta_d));
  tss_addr #(.TEX_BYTES(TEX_BYTES), .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_addr_e (
    .clk(clk), .en({en4, en3, en2}), .shape(emissive_shape), .fu(fu), .fv(fv), .taddr(ta_e));
  tss_addr #(.TEX_BYTES(TEX_BYTES), .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_addr_o (
    .clk(clk), .en({en4, en3, en2}), .shape(opacity_shape), .fu(fu), .fv(fv), .taddr(ta_o));

  tss_store #(.TEX_BYTES(TEX_BYTES)) u_store_d (
    .clk(clk), .en(en5), .taddr(ta_d), .wr(wr_go && (sel4 == TEX_DIFFUSE)),
    .waddr(wad4), .wdata(wdt4), .texel(tx_d));
  tss_store #(.TEX_BYTES(TEX_BYTES)) u_store_e (
    .clk(clk), .en(en5), .taddr(ta_e), .wr(wr_go && (sel4 == TEX_EMISSIVE)),
    .waddr(wad4), .wdata(wdt4), .texel(tx_e));
  tss_store #(.TEX_BYTES(TEX_BYTES)) u_store_o (
    .clk(clk), .en(en5), .taddr(ta_o), .wr(wr_go && (sel4 == TEX_OPACITY)),
    .waddr(wad4), .wdata(wdt4), .texel(tx_o));

  // ---------------- shade ----------------
  texel_t base;
  res_t   shade;

  always_comb begin
    if (mode[0]) begin
      base = tx_d;
    end else begin
      base = '{r: base_color[7:0], g: base_color[15:8],
               b: base_color[23:16], a: base_color[31:24]};
    end
    shade = '{red: base.r, green: base.g, blue: base.b, alpha: base.a};
    case (mode[2:1])
      EM_TEXTURE: begin
        if (shape_ok(emissive_shape, MAX_DIM)) begin
          shade.red   = sat_add(base.r, tx_e.r >> 1);
          shade.green = sat_add(base.g, tx_e.g >> 1);
          shade.blue  = sat_add(base.b, tx_e.b >> 1);
        end
      end
      EM_CONST: begin
        shade.red   = sat_add(base.r, emissive_add[7:0]);
        shade.green = sat_add(base.g, emissive_add[15:8]);
        shade.blue  = sat_add(base.b, emissive_add[23:16]);
      end
      default: ;  // no emissive term
    endcase
    if (mode[3] && shape_ok(opacity_shape, MAX_DIM)) begin
      shade.alpha = tx_o.r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      res <= shade;
    end
  end

  // ---------------- assertions ----------------
  a_bank_to_out: assert property (@(posedge clk) disable iff (rst)
    (v5 && en6) |=> res_valid)
    else $error("bank-read stage result lost");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (v4 && !smp4 && en5) |=> !v5)
    else $error("write transaction produced a result");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (v1 && v2 && v3 && v4 && v5 && res_valid && !res_ready))
    else $error("request stalled with an empty stage");

endmodule

// ===== sim/tb_texture_sample_shade.sv =====
// Self-checking testbench for texture_sample_shade: random texel writes and samples
// over APB-programmed texture shapes and shading modes. Depends on tss_pkg and the RTL.
`timescale 1ns / 100ps

module tb_texture_sample_shade;
  import tss_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        res_valid;
  logic        res_ready;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  texture_sample_shade u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the block's registers and texel stores
  logic [26:0] shp_dif, shp_emi, shp_opa;
  logic [31:0] base_rgba;
  logic [23:0] emi_const;
  logic [3:0]  shade_mode;
  logic [7:0]  dif_mem [65536];
  logic [7:0]  emi_mem [65536];
  logic [7:0]  opa_mem [65536];

  // Bytes already written, tracked at generation time so no sample reads junk
  bit          dif_filled [65536];
  bit          emi_filled [65536];
  bit          opa_filled [65536];

  req_t        req_pending_q [$];
  res_t        color_expect_q [$];
  int          errors;
  int          colors_seen;
  int          items_made;
  bit          took;

  // Sender and receiver pacing state
  int          burst_left;
  int          gap_left;
  int          pat_left;
  int          pat_kind;
  int          long_left;
  bit          long_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Texel location for a shape and coordinate pair; 0 when the lookup gives white
  function automatic bit texel_loc(input logic [26:0] shape, input logic [31:0] cu,
                                   input logic [31:0] cv, output longint unsigned idx,
                                   output longint unsigned chans);
    longint unsigned w, h, fu, fv, x, y;
    w = 64'(shape[11:0]);
    h = 64'(shape[23:12]);
    chans = 64'(shape[26:24]);
    idx = 0;
    if (w == 0 || h == 0 || chans == 0 || w > 4096 || h > 4096) return 1'b0;
    fu = 64'(cu[15:0]);
    fv = 64'd65536 - 64'(cv[15:0]);
    x = (fu * w) >> 16;
    y = (fv * h) >> 16;
    if (x > w - 1) x = w - 1;
    if (y > h - 1) y = h - 1;
    idx = (y * w + x) * chans;
    return (idx + chans - 1) < 65536;
  endfunction

  function automatic bit shape_valid(input logic [26:0] shape);
    return shape[11:0] != 0 && shape[23:12] != 0 && shape[26:24] != 0;
  endfunction

  function automatic logic [7:0] store_byte(input logic [1:0] which, input longint unsigned a);
    case (which)
      TEX_DIFFUSE:  return dif_mem[a];
      TEX_EMISSIVE: return emi_mem[a];
      default:      return opa_mem[a];
    endcase
  endfunction

  function automatic texel_t fetch_texel(input logic [1:0] which, input logic [26:0] shape,
                                         input logic [31:0] cu, input logic [31:0] cv);
    longint unsigned idx, c;
    texel_t t;
    if (!texel_loc(shape, cu, cv, idx, c)) return '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    t.r = store_byte(which, idx);
    t.g = c > 1 ? store_byte(which, idx + 1) : t.r;
    t.b = c > 2 ? store_byte(which, idx + 2) : t.r;
    t.a = c > 3 ? store_byte(which, idx + 3) : 8'hFF;
    return t;
  endfunction

  function automatic logic [7:0] add_clip(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

  function automatic res_t shade_color(input logic [31:0] cu, input logic [31:0] cv);
    texel_t col, e, o;
    res_t r;
    if (shade_mode[0]) col = fetch_texel(TEX_DIFFUSE, shp_dif, cu, cv);
    else col = '{base_rgba[7:0], base_rgba[15:8], base_rgba[23:16], base_rgba[31:24]};
    if (shade_mode[2:1] == EM_TEXTURE && shape_valid(shp_emi)) begin
      e = fetch_texel(TEX_EMISSIVE, shp_emi, cu, cv);
      col.r = add_clip(col.r, e.r >> 1);
      col.g = add_clip(col.g, e.g >> 1);
      col.b = add_clip(col.b, e.b >> 1);
    end else if (shade_mode[2:1] == EM_CONST) begin
      col.r = add_clip(col.r, emi_const[7:0]);
      col.g = add_clip(col.g, emi_const[15:8]);
      col.b = add_clip(col.b, emi_const[23:16]);
    end
    if (shade_mode[3] && shape_valid(shp_opa)) begin
      o = fetch_texel(TEX_OPACITY, shp_opa, cu, cv);
      col.a = o.r;
    end
    r.red = col.r;
    r.green = col.g;
    r.blue = col.b;
    r.alpha = col.a;
    return r;
  endfunction

  task automatic report(input string msg);
    $display("mismatch: %s at %0t", msg, $realtime);
    errors++;
  endtask

  // Queue a texel write transaction and mark the byte as filled
  task automatic push_write(input logic [1:0] sel, input logic [15:0] a, input logic [7:0] val);
    req_t it;
    it.req_type = 1'b0;
    it.tex_select = sel;
    it.byte_addr = a;
    it.byte_value = val;
    it.coord_u = $urandom;
    it.coord_v = $urandom;
    case (sel)
      TEX_DIFFUSE:  dif_filled[a] = 1'b1;
      TEX_EMISSIVE: emi_filled[a] = 1'b1;
      TEX_OPACITY:  opa_filled[a] = 1'b1;
      default: ;
    endcase
    items_made++;
    req_pending_q.push_back(it);
  endtask

  // Fill any texel bytes the sample would read that have never been written
  task automatic fill_for(input logic [1:0] sel, input logic [26:0] shape,
                          input logic [31:0] cu, input logic [31:0] cv);
    longint unsigned idx, c, k;
    bit done;
    if (!texel_loc(shape, cu, cv, idx, c)) return;
    for (k = 0; k < c && k < 4; k++) begin
      case (sel)
        TEX_DIFFUSE:  done = dif_filled[idx + k];
        TEX_EMISSIVE: done = emi_filled[idx + k];
        default:      done = opa_filled[idx + k];
      endcase
      if (!done) push_write(sel, 16'(idx + k), 8'($urandom));
    end
  endtask

  task automatic push_sample(input logic [31:0] cu, input logic [31:0] cv);
    req_t it;
    if (shade_mode[0]) fill_for(TEX_DIFFUSE, shp_dif, cu, cv);
    if (shade_mode[2:1] == EM_TEXTURE) fill_for(TEX_EMISSIVE, shp_emi, cu, cv);
    if (shade_mode[3]) fill_for(TEX_OPACITY, shp_opa, cu, cv);
    it.req_type = 1'b1;
    it.tex_select = 2'($urandom);
    it.byte_addr = 16'($urandom);
    it.byte_value = 8'($urandom);
    it.coord_u = cu;
    it.coord_v = cv;
    items_made++;
    req_pending_q.push_back(it);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return {16'($urandom_range(0, 65535)), 16'h0000};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [26:0] rand_shape();
    case ($urandom_range(0, 9))
      0: return 27'd0;
      1: return 27'($urandom);
      2: return {3'd7, 12'd4095, 12'd4095};
      3: return {3'd0, 12'($urandom_range(1, 16)), 12'($urandom_range(1, 16))};
      default: return {3'($urandom_range(1, 7)), 12'($urandom_range(1, 16)),
                       12'($urandom_range(1, 16))};
    endcase
  endfunction

  // APB write: setup, then access; the register takes the value at the access edge
  task automatic reg_write(input logic [2:0] index, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (index)
      REG_DIFFUSE_SHAPE:  shp_dif = value[26:0];
      REG_EMISSIVE_SHAPE: shp_emi = value[26:0];
      REG_OPACITY_SHAPE:  shp_opa = value[26:0];
      REG_BASE_COLOR:     base_rgba = value;
      REG_EMISSIVE_ADD:   emi_const = value[23:0];
      REG_MODE:           shade_mode = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drain everything, then give in-flight writes time to land
  task automatic wait_idle();
    while (req_pending_q.size() != 0 || req_valid || color_expect_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Sender: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || took) begin
      if (gap_left > 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (req_pending_q.size() != 0) begin
        req <= req_pending_q.pop_front();
        req_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
    took = 1'b0;
  end

  // Receiver: one long hold-off to back up the pipeline, otherwise shifting patterns
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (long_left > 0) begin
      long_left--;
      res_ready <= 1'b0;
    end else if (!long_done && colors_seen >= 40) begin
      long_done = 1'b1;
      long_left = 300;
      res_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left = $urandom_range(1, 30);
        pat_kind = $urandom_range(0, 2);
      end
      pat_left--;
      case (pat_kind)
        0: res_ready <= 1'b1;
        1: res_ready <= 1'($urandom_range(0, 1));
        default: res_ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        took = 1'b1;
        if (req.req_type == 1'b0) begin
          case (req.tex_select)
            TEX_DIFFUSE:  dif_mem[req.byte_addr] = req.byte_value;
            TEX_EMISSIVE: emi_mem[req.byte_addr] = req.byte_value;
            TEX_OPACITY:  opa_mem[req.byte_addr] = req.byte_value;
            default: ;
          endcase
        end else begin
          color_expect_q.push_back(shade_color(req.coord_u, req.coord_v));
        end
      end
      if (res_valid && res_ready) begin
        colors_seen++;
        if (color_expect_q.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          res_t want;
          want = color_expect_q.pop_front();
          if (res.red !== want.red)
            report($sformatf("red got %0d expected %0d", res.red, want.red));
          if (res.green !== want.green)
            report($sformatf("green got %0d expected %0d", res.green, want.green));
          if (res.blue !== want.blue)
            report($sformatf("blue got %0d expected %0d", res.blue, want.blue));
          if (res.alpha !== want.alpha)
            report($sformatf("alpha got %0d expected %0d", res.alpha, want.alpha));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [3:0]  modes [14];
    logic [31:0] edges [6];
    int n, i, j;
    modes = '{4'd11, 4'd0, 4'd15, 4'd1, 4'd3, 4'd5, 4'd9, 4'd13, 4'd7, 4'd2, 4'd4, 4'd8,
              4'd6, 4'd14};
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0000_FFFF, 32'h0001_0000,
              32'hFFFF_FFFF};
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    res_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    colors_seen = 0;
    items_made = 0;
    took = 1'b0;
    burst_left = 0;
    gap_left = 0;
    pat_left = 0;
    pat_kind = 0;
    long_left = 0;
    long_done = 1'b0;
    shp_dif = '0;
    shp_emi = '0;
    shp_opa = '0;
    base_rgba = 32'hFFFF_FFFF;
    emi_const = '0;
    shade_mode = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: constant white, no textures
    push_sample(32'h0, 32'h0);
    push_sample($urandom, $urandom);
    wait_idle();

    // Directed: all coordinate extremes, ignored writes, byte extremes
    reg_write(REG_DIFFUSE_SHAPE, {5'd0, 3'd4, 12'd4, 12'd4});
    reg_write(REG_EMISSIVE_SHAPE, {5'd0, 3'd1, 12'd3, 12'd5});
    reg_write(REG_OPACITY_SHAPE, {5'd0, 3'd7, 12'd2, 12'd3});
    reg_write(REG_BASE_COLOR, 32'h0000_0000);
    reg_write(REG_EMISSIVE_ADD, 32'h00FF_FFFF);
    reg_write(REG_MODE, {28'd0, 1'b1, EM_TEXTURE, 1'b1});
    push_write(2'd3, 16'hFFFF, 8'hFF);
    push_write(TEX_DIFFUSE, 16'hFFFF, 8'h00);
    push_write(TEX_OPACITY, 16'hFFFF, 8'hFF);
    for (i = 0; i < 6; i++) push_sample(edges[i], edges[(i + 3) % 6]);
    for (i = 0; i < 6; i++) push_sample(edges[5 - i], edges[i]);
    wait_idle();

    // Random phases over modes, shapes and constants
    for (j = 0; j < 14; j++) begin
      reg_write(REG_DIFFUSE_SHAPE, 32'(rand_shape()));
      reg_write(REG_EMISSIVE_SHAPE, 32'(rand_shape()));
      reg_write(REG_OPACITY_SHAPE, 32'(rand_shape()));
      reg_write(REG_BASE_COLOR, j == 2 ? 32'hFFFF_FFFF : j == 3 ? 32'h0 : $urandom);
      reg_write(REG_EMISSIVE_ADD, j == 4 ? 32'h00FF_FFFF : j == 5 ? 32'h0 : $urandom);
      reg_write(REG_MODE, 32'(modes[j]));
      // Bound each phase by transactions made, texel fills included
      n = items_made;
      while (items_made < n + 32) begin
        if ($urandom_range(0, 3) == 0)
          push_write(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        else
          push_sample(rand_coord(), rand_coord());
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (color_expect_q.size() != 0) begin
      report($sformatf("%0d results never arrived", color_expect_q.size()));
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/tss_pkg.sv
design/tss_ram.sv
design/tss_addr.sv
design/tss_store.sv
design/texture_sample_shade.sv
sim/tb_texture_sample_shade.sv
